/* rtl/fjk_pkg.sv */
// shared types and constants for the coulomb/exchange accumulator
package fjk_pkg;

  typedef enum logic [2:0] {
    OP_LABEL   = 3'd0,
    OP_DENSITY = 3'd1,
    OP_INTEGRAL = 3'd2,
    OP_RANGED  = 3'd3,
    OP_READ    = 3'd4
  } fjk_op_e;

  localparam logic [1:0] CFG_COULOMB = 2'd0;
  localparam logic [1:0] CFG_EXCHANGE = 2'd1;
  localparam logic [1:0] CFG_RANGED = 2'd2;

  // index selectors: 0 p, 1 q, 2 r, 3 s
  // exchange terms 0..7, coulomb terms 8..11
  function automatic logic [1:0] term_trow(input logic [3:0] t);
    logic [1:0] v;
    case (t)
      4'd0, 4'd1: v = 2'd1;
      4'd2, 4'd3: v = 2'd0;
      4'd4, 4'd6: v = 2'd3;
      4'd5, 4'd7: v = 2'd2;
      4'd8, 4'd9: v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] term_tcol(input logic [3:0] t);
    logic [1:0] v;
    case (t)
      4'd0, 4'd2: v = 2'd2;
      4'd1, 4'd3: v = 2'd3;
      4'd4, 4'd5: v = 2'd0;
      4'd6, 4'd7: v = 2'd1;
      4'd8, 4'd9: v = 2'd3;
      default: v = 2'd1;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] term_drow(input logic [3:0] t);
    logic [1:0] v;
    case (t)
      4'd0, 4'd1: v = 2'd0;
      4'd2, 4'd3: v = 2'd1;
      4'd4, 4'd6: v = 2'd2;
      4'd5, 4'd7: v = 2'd3;
      4'd8: v = 2'd0;
      4'd9: v = 2'd1;
      4'd10: v = 2'd2;
      default: v = 2'd3;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] term_dcol(input logic [3:0] t);
    logic [1:0] v;
    case (t)
      4'd0, 4'd2: v = 2'd3;
      4'd1, 4'd3: v = 2'd2;
      4'd4, 4'd5: v = 2'd1;
      4'd6, 4'd7: v = 2'd0;
      4'd8: v = 2'd1;
      4'd9: v = 2'd0;
      4'd10: v = 2'd3;
      default: v = 2'd2;
    endcase
    return v;
  endfunction

  // exchange gate pairing of term t (0 qr/ps, 1 qs/pr)
  function automatic logic term_gate(input logic [3:0] t);
    logic v;
    case (t)
      4'd1, 4'd2, 4'd5, 4'd6: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch input word
    logic       apply;     // write label or density, or read
    logic       term_go;   // issue memory reads for term
    logic [3:0] term;
    logic       acc_wr;    // write back accumulated term
    logic       finish;    // drive result
  } fjk_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic        is_integral;
    logic [11:0] term_mask; // enabled terms of current integral
  } fjk_stat_t;

endpackage

/* rtl/fjk_ctrl.sv */
// sequencer for the per-item term loop
module fjk_ctrl
  import fjk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  fjk_stat_t stat_i,
  output fjk_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_MUL, S_ROUND, S_WRITE, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [3:0] term_q, term_d;

  // next enabled term at or after term_q
  logic       found;
  logic [3:0] next_term;
  always_comb begin
    found = 1'b0;
    next_term = '0;
    for (int i = 11; i >= 0; i--) begin
      if (stat_i.term_mask[i] && (4'(i) >= term_q)) begin
        found = 1'b1;
        next_term = 4'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    term_d = term_q;
    cmd_o = '0;
    cmd_o.term = term_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.apply = 1'b1;
        term_d = '0;
        state_d = stat_i.is_integral ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (found) begin
          cmd_o.term_go = 1'b1;
          cmd_o.term = next_term;
          term_d = next_term;
          state_d = S_MUL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: state_d = S_ROUND;
      S_ROUND: state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.acc_wr = 1'b1;
        if (term_q == 4'd11) state_d = S_DONE;
        else begin
          term_d = term_q + 4'd1;
          state_d = S_SCAN;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      term_q <= '0;
    end else begin
      state_q <= state_d;
      term_q <= term_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* rtl/fjk_datapath.sv */
// stores, multiplier and saturating accumulators
module fjk_datapath
  import fjk_pkg::*;
#(
  parameter int NUM_BASIS = 64,
  parameter int NUM_IRREPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fjk_cmd_t           cmd_i,
  output fjk_stat_t          stat_o,
  input  logic [2:0]         operation_i,
  input  logic [5:0]         index_p_i,
  input  logic [5:0]         index_q_i,
  input  logic [5:0]         index_r_i,
  input  logic [5:0]         index_s_i,
  input  logic signed [31:0] amount_i,
  input  logic [2:0]         irrep_label_i,
  input  logic [2:0]         coulomb_sym_i,
  input  logic [2:0]         exchange_sym_i,
  input  logic [2:0]         ranged_sym_i,
  output logic               result_valid_o,
  output logic signed [47:0] coulomb_element_o,
  output logic signed [47:0] exchange_element_o,
  output logic signed [47:0] ranged_exchange_element_o,
  output logic               saturated_o
);

  localparam int IW = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;
  localparam int CELLS = NUM_BASIS * NUM_BASIS;
  localparam int AW = 2 * IW;
  localparam int CW = $clog2(CELLS + 1);
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

  // captured word
  logic [2:0]         op_q;
  logic [5:0]         ix_q [4];
  logic signed [31:0] amt_q;
  logic [2:0]         lbl_q;
  logic [2:0]         irr_q [4];

  // label table
  logic [2:0] irrep_q [NUM_BASIS];

  // memories
  logic signed [31:0] dens_mem [CELLS];
  logic signed [47:0] coul_mem [CELLS];
  logic signed [47:0] exch_mem [CELLS];
  logic signed [47:0] rexc_mem [CELLS];

  // clearing sweep of the accumulators after reset
  logic [CW-1:0] clr_q;
  logic          clearing;
  assign clearing = (clr_q != CW'(CELLS));

  logic in_range_pq, in_range_all;
  always_comb begin
    in_range_pq = (32'(ix_q[0]) < NUM_BASIS) && (32'(ix_q[1]) < NUM_BASIS);
    in_range_all = in_range_pq && (32'(ix_q[2]) < NUM_BASIS)
                   && (32'(ix_q[3]) < NUM_BASIS);
  end

  function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c);
    return AW'(32'(r[IW-1:0]) * NUM_BASIS + 32'(c[IW-1:0]));
  endfunction

  // term masks and gates
  logic       ranged;
  logic [7:0] kmask;
  logic [3:0] jmask;
  logic       jgate, gate0, gate1;
  logic [2:0] ksym;
  always_comb begin
    logic pq, rs, prqs;
    pq = ix_q[0] != ix_q[1];
    rs = ix_q[2] != ix_q[3];
    prqs = (ix_q[0] != ix_q[2]) || (ix_q[1] != ix_q[3]);
    ranged = (op_q == OP_RANGED);
    ksym = ranged ? ranged_sym_i : exchange_sym_i;
    if (pq && rs && prqs) begin jmask = 4'hF; kmask = 8'hFF; end
    else if (pq && rs) begin jmask = 4'h3; kmask = 8'h0F; end
    else if (pq) begin jmask = 4'h7; kmask = 8'h55; end
    else if (rs) begin jmask = 4'hD; kmask = 8'h33; end
    else if (ix_q[0] != ix_q[2]) begin jmask = 4'h5; kmask = 8'h11; end
    else begin jmask = 4'h1; kmask = 8'h01; end
    jgate = ((irr_q[0] ^ irr_q[1]) == (irr_q[2] ^ irr_q[3]))
            && ((irr_q[0] ^ irr_q[1]) == coulomb_sym_i);
    gate0 = ((irr_q[1] ^ irr_q[2]) == (irr_q[0] ^ irr_q[3]))
            && ((irr_q[1] ^ irr_q[2]) == ksym);
    gate1 = ((irr_q[1] ^ irr_q[3]) == (irr_q[0] ^ irr_q[2]))
            && ((irr_q[1] ^ irr_q[3]) == ksym);
  end

  always_comb begin
    logic [11:0] m;
    for (int t = 0; t < 8; t++)
      m[t] = kmask[t] && (term_gate(4'(t)) ? gate1 : gate0);
    for (int t = 0; t < 4; t++)
      m[8+t] = jmask[t] && jgate && !ranged;
    stat_o.term_mask = m;
    stat_o.is_integral = ((op_q == OP_INTEGRAL) || (op_q == OP_RANGED)) && in_range_all;
  end

  // term addressing
  logic [AW-1:0] t_addr, d_addr;
  assign t_addr = addr_of(ix_q[term_trow(cmd_i.term)], ix_q[term_tcol(cmd_i.term)]);
  assign d_addr = addr_of(ix_q[term_drow(cmd_i.term)], ix_q[term_dcol(cmd_i.term)]);

  logic [AW-1:0]      taddr_q;
  logic               tcoul_q;
  logic signed [31:0] dens_rd_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] acc_hold_q;
  logic signed [36:0] add_q;
  logic               sat_q;
  logic [AW-1:0]      rd_addr;
  logic               rd_ok_q;
  assign rd_addr = addr_of(ix_q[0], ix_q[1]);

  // capture and label table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BASIS; i++) irrep_q[i] <= '0;
    end else if (cmd_i.apply && op_q == OP_LABEL && 32'(ix_q[0]) < NUM_BASIS
                 && 32'(lbl_q) < NUM_IRREPS) begin
      irrep_q[ix_q[0][IW-1:0]] <= lbl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      ix_q[0] <= index_p_i;
      ix_q[1] <= index_q_i;
      ix_q[2] <= index_r_i;
      ix_q[3] <= index_s_i;
      amt_q <= amount_i;
      lbl_q <= irrep_label_i;
      irr_q[0] <= irrep_q[index_p_i[IW-1:0]];
      irr_q[1] <= irrep_q[index_q_i[IW-1:0]];
    end
    // labels of r and s are read while the word is decoded
    if (cmd_i.apply) begin
      irr_q[2] <= irrep_q[ix_q[2][IW-1:0]];
      irr_q[3] <= irrep_q[ix_q[3][IW-1:0]];
    end
  end

  // density memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && op_q == OP_DENSITY && in_range_pq)
      dens_mem[rd_addr] <= amt_q;
    dens_rd_q <= dens_mem[d_addr];
  end

  // accumulator memories: one write port, one registered read port each
  logic signed [47:0] coul_rd_q, exch_rd_q, rexc_rd_q;
  logic [AW-1:0]      acc_raddr;
  logic signed [47:0] sum_sat;
  logic               sum_ovf;
  assign acc_raddr = cmd_i.term_go ? t_addr : rd_addr;

  always_ff @(posedge clk_i) begin
    coul_rd_q <= coul_mem[acc_raddr];
    exch_rd_q <= exch_mem[acc_raddr];
    rexc_rd_q <= rexc_mem[acc_raddr];
    if (clearing) begin
      coul_mem[clr_q[AW-1:0]] <= '0;
      exch_mem[clr_q[AW-1:0]] <= '0;
      rexc_mem[clr_q[AW-1:0]] <= '0;
    end else if (cmd_i.acc_wr) begin
      if (tcoul_q) coul_mem[taddr_q] <= sum_sat;
      else if (ranged) rexc_mem[taddr_q] <= sum_sat;
      else exch_mem[taddr_q] <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clearing) clr_q <= clr_q + CW'(1);
  end

  // mul stage, round stage
  logic term_mul_q, term_round_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_mul_q <= 1'b0;
      term_round_q <= 1'b0;
    end else begin
      term_mul_q <= cmd_i.term_go;
      term_round_q <= term_mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.term_go) begin
      taddr_q <= t_addr;
      tcoul_q <= cmd_i.term[3];
    end
    if (term_mul_q) begin
      prod_q <= 64'(dens_rd_q) * 64'(amt_q);
      acc_hold_q <= tcoul_q ? coul_rd_q : (ranged ? rexc_rd_q : exch_rd_q);
    end
    if (term_round_q) add_q <= 37'((prod_q + 64'sd134217728) >>> 28);
  end

  // saturating add
  always_comb begin
    logic signed [49:0] s;
    s = 50'(acc_hold_q) + 50'(add_q);
    sum_ovf = 1'b0;
    sum_sat = s[47:0];
    if (s > 50'(ACC_MAX)) begin sum_sat = ACC_MAX; sum_ovf = 1'b1; end
    else if (s < 50'(ACC_MIN)) begin sum_sat = ACC_MIN; sum_ovf = 1'b1; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sat_q <= 1'b0;
    else if (cmd_i.capture) sat_q <= 1'b0;
    else if (cmd_i.acc_wr && sum_ovf) sat_q <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ok_q <= 1'b0;
    else if (cmd_i.apply) rd_ok_q <= (op_q == OP_READ) && in_range_pq;
  end

  // result, one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      coulomb_element_o <= rd_ok_q ? coul_rd_q : '0;
      exchange_element_o <= rd_ok_q ? exch_rd_q : '0;
      ranged_exchange_element_o <= rd_ok_q ? rexc_rd_q : '0;
      saturated_o <= sat_q;
    end
  end

endmodule

/* rtl/fock_jk_integral_accumulator.sv */
// top level of the coulomb/exchange integral accumulator
// label, density, read and unknown words go from decode straight to the result; an
// integral first runs, for each applied term (up to 12), a read / multiply / round /
// write-back loop, and ends the term scan early after the last coulomb term
// one word at a time: start is taken only while busy is low
// after reset all NUM_BASIS*NUM_BASIS accumulator cells are cleared, busy high
// results appear for one cycle with result_valid_o, the receiver cannot stall
module fock_jk_integral_accumulator
  import fjk_pkg::*;
#(
  parameter int NUM_BASIS = 64,
  parameter int NUM_IRREPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic [5:0]         index_p_i,
  input  logic [5:0]         index_q_i,
  input  logic [5:0]         index_r_i,
  input  logic [5:0]         index_s_i,
  input  logic signed [31:0] amount_i,
  input  logic [2:0]         irrep_label_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [2:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic signed [47:0] coulomb_element_o,
  output logic signed [47:0] exchange_element_o,
  output logic signed [47:0] ranged_exchange_element_o,
  output logic               saturated_o
);

  localparam int CLR_W = $clog2(NUM_BASIS * NUM_BASIS + 1);

  // symmetry registers
  logic [2:0] coul_sym_q, exch_sym_q, rexc_sym_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coul_sym_q <= '0;
      exch_sym_q <= '0;
      rexc_sym_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COULOMB: coul_sym_q <= cfg_data_i;
        CFG_EXCHANGE: exch_sym_q <= cfg_data_i;
        CFG_RANGED: rexc_sym_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fjk_cmd_t  cmd;
  fjk_stat_t stat;
  logic      ctrl_busy;
  logic      clr_busy_q;
  logic [CLR_W-1:0] clr_cnt_q;

  // mirrors the datapath clearing sweep so no word is taken during it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      clr_busy_q <= (32'(clr_cnt_q) != NUM_BASIS * NUM_BASIS - 1);
    end
  end

  assign busy = ctrl_busy || clr_busy_q;

  fjk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start && !clr_busy_q),
    .busy   (ctrl_busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fjk_datapath #(
    .NUM_BASIS  (NUM_BASIS),
    .NUM_IRREPS (NUM_IRREPS)
  ) u_dp (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cmd_i                     (cmd),
    .stat_o                    (stat),
    .operation_i               (operation_i),
    .index_p_i                 (index_p_i),
    .index_q_i                 (index_q_i),
    .index_r_i                 (index_r_i),
    .index_s_i                 (index_s_i),
    .amount_i                  (amount_i),
    .irrep_label_i             (irrep_label_i),
    .coulomb_sym_i             (coul_sym_q),
    .exchange_sym_i            (exch_sym_q),
    .ranged_sym_i              (rexc_sym_q),
    .result_valid_o            (result_valid_o),
    .coulomb_element_o         (coulomb_element_o),
    .exchange_element_o        (exchange_element_o),
    .ranged_exchange_element_o (ranged_exchange_element_o),
    .saturated_o               (saturated_o)
  );

endmodule

/* verif/fock_jk_integral_accumulator_tb.sv */
// self-checking testbench for the coulomb/exchange integral accumulator
`timescale 1ns / 100ps

module fock_jk_integral_accumulator_tb
  import fjk_pkg::*;
;

  localparam int NB = 64;
  localparam int CELL_COUNT = NB * NB;
  // an integral applies at most 12 terms, each read, multiplied, rounded and written back
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 47);
  localparam logic signed [31:0] AMT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] AMT_MIN = 32'sh80000000;
  localparam int PUMP_COUNT = 24;
  localparam int PHASE_WORDS = 100;

  // permutation tables, selectors 0 p, 1 q, 2 r, 3 s
  localparam bit [1:0] XT_ROW [8] = '{1, 1, 0, 0, 3, 2, 3, 2};
  localparam bit [1:0] XT_COL [8] = '{2, 3, 2, 3, 0, 0, 1, 1};
  localparam bit [1:0] XD_ROW [8] = '{0, 0, 1, 1, 2, 3, 2, 3};
  localparam bit [1:0] XD_COL [8] = '{3, 2, 3, 2, 1, 1, 0, 0};
  localparam bit       X_PAIR [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
  localparam bit [1:0] CT_ROW [4] = '{2, 2, 0, 0};
  localparam bit [1:0] CT_COL [4] = '{3, 3, 1, 1};
  localparam bit [1:0] CD_ROW [4] = '{0, 1, 2, 3};
  localparam bit [1:0] CD_COL [4] = '{1, 0, 3, 2};

  typedef struct {
    longint coul;
    longint exch;
    longint rexch;
    bit     sat;
  } elements_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         operation_i = OP_LABEL;
  logic [5:0]         index_p_i = '0;
  logic [5:0]         index_q_i = '0;
  logic [5:0]         index_r_i = '0;
  logic [5:0]         index_s_i = '0;
  logic signed [31:0] amount_i = '0;
  logic [2:0]         irrep_label_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_COULOMB;
  logic [2:0]         cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [47:0] coulomb_element_o;
  logic signed [47:0] exchange_element_o;
  logic signed [47:0] ranged_exchange_element_o;
  logic               saturated_o;

  fock_jk_integral_accumulator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .operation_i(operation_i),
    .index_p_i(index_p_i),
    .index_q_i(index_q_i),
    .index_r_i(index_r_i),
    .index_s_i(index_s_i),
    .amount_i(amount_i),
    .irrep_label_i(irrep_label_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o),
    .coulomb_element_o(coulomb_element_o),
    .exchange_element_o(exchange_element_o),
    .ranged_exchange_element_o(ranged_exchange_element_o),
    .saturated_o(saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the block state
  bit [2:0]           sym_coul, sym_exch, sym_rexch;
  bit [2:0]           irrep_of [NB];
  logic signed [31:0] dens [CELL_COUNT];
  bit                 dens_known [CELL_COUNT];
  longint             coul_acc [CELL_COUNT];
  longint             exch_acc [CELL_COUNT];
  longint             rexch_acc [CELL_COUNT];

  elements_t pending_q[$];
  int  mismatches = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  sat_seen = 0;
  int  cycles = 0;
  bit  calm = 0;       // no idle bursts when set
  // current random-phase index pool and label pair
  bit [5:0] pool [6];
  bit [2:0] alt_label;

  // rounded Q.28 product of density and integral value
  function automatic longint scaled_product(logic signed [31:0] d, logic signed [31:0] v);
    longint x;
    x = longint'(d) * longint'(v) + (64'sd1 <<< 27);
    return x >>> 28;
  endfunction

  function automatic longint clamp_add(longint acc, longint add, output bit hit);
    longint s;
    s = acc + add;
    hit = 1'b0;
    if (s > ACC_HI) begin
      s = ACC_HI;
      hit = 1'b1;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
      hit = 1'b1;
    end
    return s;
  endfunction

  // apply one accepted word to the shadow state and queue its result
  function automatic void model_word(logic [2:0] op, bit [5:0] ip, bit [5:0] iq, bit [5:0] ir,
                                     bit [5:0] is, logic signed [31:0] amt, bit [2:0] lab);
    elements_t e;
    bit [5:0] ix [4];
    bit [2:0] lp, lq, lr, ls, ksym;
    bit jg, hit, ranged;
    bit xg [2];
    bit [3:0] jmask;
    bit [7:0] kmask;
    int a, t;
    e = '{0, 0, 0, 0};
    ix = '{ip, iq, ir, is};
    a = ip * NB + iq;
    case (op)
      OP_LABEL: irrep_of[ip] = lab;
      OP_DENSITY: begin
        dens[a] = amt;
        dens_known[a] = 1'b1;
      end
      OP_READ: begin
        e.coul = coul_acc[a];
        e.exch = exch_acc[a];
        e.rexch = rexch_acc[a];
      end
      OP_INTEGRAL, OP_RANGED: begin
        ranged = (op == OP_RANGED);
        lp = irrep_of[ip];
        lq = irrep_of[iq];
        lr = irrep_of[ir];
        ls = irrep_of[is];
        ksym = ranged ? sym_rexch : sym_exch;
        jg = ((lp ^ lq) == (lr ^ ls)) && ((lp ^ lq) == sym_coul);
        xg[0] = ((lq ^ lr) == (lp ^ ls)) && ((lq ^ lr) == ksym);
        xg[1] = ((lq ^ ls) == (lp ^ lr)) && ((lq ^ ls) == ksym);
        // distinct permutations left by the index equalities
        if (ip != iq && ir != is && (ip != ir || iq != is)) begin
          jmask = 4'hf; kmask = 8'hff;
        end else if (ip != iq && ir != is) begin
          jmask = 4'h3; kmask = 8'h0f;
        end else if (ip != iq) begin
          jmask = 4'h7; kmask = 8'h55;
        end else if (ir != is) begin
          jmask = 4'hd; kmask = 8'h33;
        end else if (ip != ir) begin
          jmask = 4'h5; kmask = 8'h11;
        end else begin
          jmask = 4'h1; kmask = 8'h01;
        end
        if (!ranged && jg) begin
          for (t = 0; t < 4; t++) begin
            if (jmask[t]) begin
              a = ix[CT_ROW[t]] * NB + ix[CT_COL[t]];
              coul_acc[a] = clamp_add(coul_acc[a],
                scaled_product(dens[ix[CD_ROW[t]] * NB + ix[CD_COL[t]]], amt), hit);
              e.sat |= hit;
            end
          end
        end
        for (t = 0; t < 8; t++) begin
          if (kmask[t] && xg[X_PAIR[t]]) begin
            a = ix[XT_ROW[t]] * NB + ix[XT_COL[t]];
            if (ranged) begin
              rexch_acc[a] = clamp_add(rexch_acc[a],
                scaled_product(dens[ix[XD_ROW[t]] * NB + ix[XD_COL[t]]], amt), hit);
            end else begin
              exch_acc[a] = clamp_add(exch_acc[a],
                scaled_product(dens[ix[XD_ROW[t]] * NB + ix[XD_COL[t]]], amt), hit);
            end
            e.sat |= hit;
          end
        end
      end
      default: ;  // unknown codes leave the state alone
    endcase
    pending_q.push_back(e);
  endfunction

  // result checker, outputs sampled at the rising edge
  always @(posedge clk_i) begin
    elements_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (saturated_o) sat_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = pending_q.pop_front();
        if (coulomb_element_o !== e.coul[47:0] || exchange_element_o !== e.exch[47:0] ||
            ranged_exchange_element_o !== e.rexch[47:0] || saturated_o !== e.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch result %0d: exp j=%0d k=%0d kr=%0d sat=%0b", results_seen,
                     $signed(e.coul[47:0]), $signed(e.exch[47:0]),
                     $signed(e.rexch[47:0]), e.sat);
            $display("  got j=%0d k=%0d kr=%0d sat=%0b", coulomb_element_o,
                     exchange_element_o, ranged_exchange_element_o, saturated_o);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // drive one word at a falling edge and hold it until busy is low; the word is
  // taken at the next rising edge and the task returns on the falling edge after
  task automatic send_word(logic [2:0] op, bit [5:0] ip, bit [5:0] iq, bit [5:0] ir,
                           bit [5:0] is, logic signed [31:0] amt, bit [2:0] lab);
    operation_i = op;
    index_p_i = ip;
    index_q_i = iq;
    index_r_i = ir;
    index_s_i = is;
    amount_i = amt;
    irrep_label_i = lab;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    model_word(op, ip, iq, ir, is, amt, lab);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return AMT_MAX;
      1: return AMT_MIN;
      2: return 32'sd0;
      3: return $signed(32'($urandom_range(0, 1 << 29)));
      default: return $signed($urandom());
    endcase
  endfunction

  // integrals may only read density cells that were written before
  task automatic send_integral(logic [2:0] op, bit [5:0] ip, bit [5:0] iq, bit [5:0] ir,
                               bit [5:0] is, logic signed [31:0] amt);
    bit [5:0] ix [4];
    int a, b, c;
    ix = '{ip, iq, ir, is};
    for (a = 0; a < 4; a++) begin
      for (b = 0; b < 4; b++) begin
        c = ix[a] * NB + ix[b];
        if (a != b && !dens_known[c]) begin
          send_word(OP_DENSITY, ix[a], ix[b], 6'($urandom()), 6'($urandom()),
                    pick_amount(), 3'($urandom()));
          idle_gap();
        end
      end
    end
    send_word(op, ip, iq, ir, is, amt, 3'($urandom()));
  endtask

  // quiet the input and wait until every expected word has come back
  task automatic settle();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [2:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    while (!cfg_ready_o) @(negedge clk_i);
    case (idx)
      CFG_COULOMB: sym_coul = val;
      CFG_EXCHANGE: sym_exch = val;
      default: sym_rexch = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_symmetries(bit [2:0] j, bit [2:0] k, bit [2:0] kr);
    settle();
    write_reg(CFG_COULOMB, j);
    write_reg(CFG_EXCHANGE, k);
    write_reg(CFG_RANGED, kr);
  endtask

  // one integral of every index-equality pattern, extremes of every field
  task automatic test_directed();
    set_symmetries(3'd0, 3'd0, 3'd0);
    send_word(OP_LABEL, 6'd63, 0, 0, 0, 0, 3'd7);
    send_word(OP_LABEL, 6'd1, 0, 0, 0, 0, 3'd7);
    send_word(OP_DENSITY, 6'd0, 6'd63, 6'd63, 6'd63, AMT_MAX, 3'd7);
    send_word(OP_DENSITY, 6'd63, 6'd0, 0, 0, AMT_MIN, 0);
    send_integral(OP_INTEGRAL, 6'd0, 6'd63, 6'd1, 6'd2, AMT_MAX);   // all distinct
    send_integral(OP_INTEGRAL, 6'd0, 6'd63, 6'd0, 6'd63, AMT_MIN);  // pq equal to rs
    send_integral(OP_INTEGRAL, 6'd3, 6'd4, 6'd5, 6'd5, 32'sh10000000);  // r equals s
    send_integral(OP_INTEGRAL, 6'd6, 6'd6, 6'd0, 6'd63, -32'sh08000000); // p equals q
    send_integral(OP_INTEGRAL, 6'd63, 6'd63, 6'd1, 6'd1, AMT_MAX);  // two diagonal pairs
    send_integral(OP_INTEGRAL, 6'd2, 6'd2, 6'd2, 6'd2, AMT_MAX);    // all four equal
    send_integral(OP_RANGED, 6'd63, 6'd0, 6'd1, 6'd63, AMT_MIN);
    send_word(OP_READ, 6'd63, 6'd0, 0, 0, 0, 0);
    send_word(OP_READ, 6'd1, 6'd2, 0, 0, 0, 0);
    send_word(OP_READ, 6'd2, 6'd2, 6'd63, 6'd63, AMT_MAX, 3'd7);
    send_word(3'd5, 6'd63, 6'd63, 6'd63, 6'd63, AMT_MIN, 3'd7);
    send_word(3'd7, 0, 0, 0, 0, 0, 0);
    set_symmetries(3'd7, 3'd7, 3'd7);
    send_integral(OP_INTEGRAL, 6'd0, 6'd63, 6'd1, 6'd2, AMT_MAX);
    send_integral(OP_RANGED, 6'd0, 6'd63, 6'd2, 6'd1, AMT_MIN);
    send_word(OP_READ, 6'd0, 6'd63, 0, 0, 0, 0);
    send_word(OP_READ, 6'd63, 6'd0, 0, 0, 0, 0);
  endtask

  // repeated extreme products on one accumulator cell of each store, back to back
  task automatic test_saturation();
    int n;
    calm = 1;
    set_symmetries(3'd0, 3'd0, 3'd0);
    send_word(OP_LABEL, 6'd9, 0, 0, 0, 0, 3'd5);
    send_word(OP_LABEL, 6'd10, 0, 0, 0, 0, 3'd2);
    send_word(OP_DENSITY, 6'd9, 6'd9, 0, 0, AMT_MIN, 0);
    send_word(OP_DENSITY, 6'd10, 6'd10, 0, 0, AMT_MIN, 0);
    for (n = 0; n < PUMP_COUNT; n++)
      send_word(OP_INTEGRAL, 6'd9, 6'd9, 6'd9, 6'd9, AMT_MIN, 0);
    for (n = 0; n < PUMP_COUNT; n++)
      send_word(OP_RANGED, 6'd10, 6'd10, 6'd10, 6'd10, AMT_MAX, 0);
    send_word(OP_READ, 6'd9, 6'd9, 0, 0, 0, 0);
    send_word(OP_READ, 6'd10, 6'd10, 0, 0, 0, 0);
    calm = 0;
  endtask

  function automatic bit [5:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 6'($urandom());
    return pool[$urandom_range(0, 5)];
  endfunction

  // mixed random words over a small index pool so that equalities and gates hit
  task automatic test_random_phase(int count, bit wide_pool);
    int n, sel;
    bit [2:0] lab;
    alt_label = 3'($urandom_range(1, 7));
    for (n = 0; n < 6; n++) pool[n] = 6'($urandom());
    if (wide_pool) begin
      pool[0] = 6'd0;
      pool[1] = 6'd63;
    end
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      lab = ($urandom_range(0, 4) == 0) ? 3'($urandom()) :
            ($urandom_range(0, 1) ? alt_label : 3'd0);
      if (sel < 10)
        send_word(OP_LABEL, pick_index(), 6'($urandom()), 6'($urandom()), 6'($urandom()),
                  $signed($urandom()), lab);
      else if (sel < 18)
        send_word(OP_DENSITY, pick_index(), pick_index(), 6'($urandom()), 6'($urandom()),
                  pick_amount(), lab);
      else if (sel < 60)
        send_integral(OP_INTEGRAL, pick_index(), pick_index(), pick_index(), pick_index(),
                      pick_amount());
      else if (sel < 78)
        send_integral(OP_RANGED, pick_index(), pick_index(), pick_index(), pick_index(),
                      pick_amount());
      else if (sel < 96)
        send_word(OP_READ, pick_index(), pick_index(), 6'($urandom()), 6'($urandom()),
                  $signed($urandom()), lab);
      else
        send_word(3'($urandom_range(5, 7)), 6'($urandom()), 6'($urandom()), 6'($urandom()),
                  6'($urandom()), $signed($urandom()), lab);
      idle_gap();
    end
  endtask

  function automatic bit [2:0] pick_sym();
    case ($urandom_range(0, 2))
      0: return 3'd0;
      1: return alt_label;
      default: return 3'($urandom());
    endcase
  endfunction

  initial begin
    int ph;
    for (int c = 0; c < CELL_COUNT; c++) begin
      dens[c] = '0;
      dens_known[c] = 1'b0;
      coul_acc[c] = 0;
      exch_acc[c] = 0;
      rexch_acc[c] = 0;
    end
    for (int b = 0; b < NB; b++) irrep_of[b] = '0;
    sym_coul = '0;
    sym_exch = '0;
    sym_rexch = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_saturation();
    alt_label = 3'd3;
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_symmetries(3'd0, 3'd0, 3'd0);
        1: set_symmetries(3'd7, 3'd7, 3'd7);
        default: set_symmetries(pick_sym(), pick_sym(), pick_sym());
      endcase
      calm = (ph == 6);
      test_random_phase(PHASE_WORDS, ph < 2);
    end

    settle();
    $display("sent %0d words, checked %0d results, %0d of them saturated", words_sent,
             results_seen, sat_seen);
    $display("covered all operations, symmetry settings 0 to 7 and extreme products");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
